// ----- design/rpwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpwd_pkg
// Shared types and constants of the RGB Pearson watermark detector.
// ----------------------------------------------------------------------------
package rpwd_pkg;

   localparam int NUM_CH      = 3;
   localparam int PIX_W       = 8;
   localparam int CNT_W       = 23;
   localparam int MAX_PIXELS  = 4194304;
   localparam int SUM_W       = 30;
   localparam int SQ_W        = 38;
   localparam int FRAC_BITS   = 15;
   localparam int PROD_W      = 62;
   localparam int ROOT_W      = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int CORR_W      = 16;
   localparam int THR_W       = 16;
   localparam int TOTAL_W     = 19;
   localparam int MAG_W       = 17;
   localparam int RECIP_SHIFT = 17;
   localparam int STEP_W      = 3;
   localparam int CNT_SEQ_W   = 5;

   localparam logic [THR_W-1:0]       THR_RESET = 16'd3277;
   localparam logic [MAG_W-1:0]       RECIP_3   = 17'd43691;
   localparam logic [FRAC_BITS:0]     COEF_ONE  = 16'd32768;

   localparam logic [1:0] VERDICT_NONE  = 2'd0;
   localparam logic [1:0] VERDICT_ABOVE = 2'd1;
   localparam logic [1:0] VERDICT_BELOW = 2'd2;

   // Multiplication steps of one channel.
   localparam logic [STEP_W-1:0] STEP_CROSS = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SXSY  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_XX_N  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_XX_S  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YY_N  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_YY_S  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_DEN   = 3'd6;

   typedef struct packed {
      logic [PIX_W-1:0] image_blue;
      logic [PIX_W-1:0] image_green;
      logic [PIX_W-1:0] image_red;
      logic [PIX_W-1:0] pattern_blue;
      logic [PIX_W-1:0] pattern_green;
      logic [PIX_W-1:0] pattern_red;
      logic             final_pixel;
   } req_data_type;

   typedef struct packed {
      logic signed [CORR_W-1:0] correlation_value;
      logic [1:0]               verdict;
   } rsp_data_type;

   typedef struct packed {
      logic [NUM_CH-1:0][SUM_W-1:0] image_sum;
      logic [NUM_CH-1:0][SUM_W-1:0] pattern_sum;
      logic [NUM_CH-1:0][SQ_W-1:0]  image_square_sum;
      logic [NUM_CH-1:0][SQ_W-1:0]  pattern_square_sum;
      logic [NUM_CH-1:0][SQ_W-1:0]  cross_product_sum;
      logic [CNT_W-1:0]             pixel_count;
   } frame_sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_RLOAD,
      ST_ROOT,
      ST_MAG,
      ST_DIV_CHK,
      ST_DIV,
      ST_ACC,
      ST_AVG,
      ST_DONE
   } back_state_type;

endpackage

// ----- design/rgb_pearson_watermark_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pearson_watermark_detector
// Accumulates paired image and pattern pixels per frame and reports the
// channel-averaged Pearson correlation with a threshold verdict.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    req_data_type, one pixel pair
//  rsp_      out        rsp_valid/rsp_ready    rsp_data_type, one per frame
//  csr_      in         csr_wr_en              csr_wr_data, detect threshold
//
//  Pixels are taken one per cycle while the frame queue has room.
//  Each queued frame is worked through in the back end: per channel, seven
//  serial multiplies, two serial square roots and a divide, all on one
//  shared datapath.
//  req_ready drops only when the frame queue is full; a stalled rsp_ handshake
//  holds the back end in its last state.
//  Reset is synchronous and clears the sums, queue and result valid flag.
// ----------------------------------------------------------------------------
module rgb_pearson_watermark_detector #(
   parameter int QUEUE_DEPTH = rpwd_pkg::QUEUE_DEPTH
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  rpwd_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output rpwd_pkg::rsp_data_type        rsp_data,
   input  wire                           csr_wr_en,
   input  wire [rpwd_pkg::THR_W-1:0]     csr_wr_data
);

   logic [rpwd_pkg::THR_W-1:0] thr_ff;
   rpwd_pkg::queue_status_type q_status;
   rpwd_pkg::frame_sums_type   push_data, head;
   logic push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rpwd_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   rpwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   rpwd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   rpwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .threshold (thr_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- design/rpwd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwd_front
// Accepts pixel beats, keeps the per-channel sums and hands a frame's sums
// to the queue on the final pixel.
// ----------------------------------------------------------------------------
module rpwd_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  rpwd_pkg::req_data_type     req_data,
   input  rpwd_pkg::queue_status_type q_status,
   output logic                       push,
   output rpwd_pkg::frame_sums_type   push_data
);

   rpwd_pkg::frame_sums_type sums_ff, sums_in;
   logic [rpwd_pkg::NUM_CH-1:0][rpwd_pkg::PIX_W-1:0] xs, ys;
   logic accept;
   logic take;

   assign req_ready = ~q_status.full;
   assign accept    = req_valid & ~q_status.full;
   assign take      = sums_ff.pixel_count < rpwd_pkg::CNT_W'(rpwd_pkg::MAX_PIXELS);
   assign xs = {req_data.image_red, req_data.image_green, req_data.image_blue};
   assign ys = {req_data.pattern_red, req_data.pattern_green, req_data.pattern_blue};

   always_comb begin
      sums_in = sums_ff;
      if (take) begin
         for (int c = 0; c < rpwd_pkg::NUM_CH; c++) begin
            sums_in.image_sum[c] = sums_ff.image_sum[c] + rpwd_pkg::SUM_W'(xs[c]);
            sums_in.pattern_sum[c] = sums_ff.pattern_sum[c] + rpwd_pkg::SUM_W'(ys[c]);
            sums_in.image_square_sum[c] = sums_ff.image_square_sum[c]
               + rpwd_pkg::SQ_W'(16'(xs[c]) * 16'(xs[c]));
            sums_in.pattern_square_sum[c] = sums_ff.pattern_square_sum[c]
               + rpwd_pkg::SQ_W'(16'(ys[c]) * 16'(ys[c]));
            sums_in.cross_product_sum[c] = sums_ff.cross_product_sum[c]
               + rpwd_pkg::SQ_W'(16'(xs[c]) * 16'(ys[c]));
         end
         sums_in.pixel_count = sums_ff.pixel_count + 1'b1;
      end
   end

   assign push      = accept & req_data.final_pixel;
   assign push_data = sums_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else if (accept) begin
         sums_ff <= req_data.final_pixel ? '0 : sums_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rpwd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwd_fifo
// Short queue of finished frame sums between the front and the back.
// ----------------------------------------------------------------------------
module rpwd_fifo #(
   parameter int DEPTH = rpwd_pkg::QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  rpwd_pkg::frame_sums_type   push_data,
   input  wire                        pop,
   output rpwd_pkg::frame_sums_type   head,
   output rpwd_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   rpwd_pkg::frame_sums_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = fill_ff == FILL_W'(DEPTH);
   assign status.empty = fill_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rpwd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpwd_back
// Works through one queued frame: serial multiplier, serial square root and
// restoring divider shared over the three channels, then the average,
// saturation and verdict into the result register.
// ----------------------------------------------------------------------------
module rpwd_back (
   input  wire                              clock,
   input  wire                              reset,
   input  rpwd_pkg::frame_sums_type         head,
   input  rpwd_pkg::queue_status_type       q_status,
   output logic                             pop,
   input  wire [rpwd_pkg::THR_W-1:0]        threshold,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output rpwd_pkg::rsp_data_type           rsp_data
);

   localparam int PW = rpwd_pkg::PROD_W;
   localparam int RW = rpwd_pkg::ROOT_W;
   localparam int FB = rpwd_pkg::FRAC_BITS;
   localparam int TW = rpwd_pkg::TOTAL_W;

   rpwd_pkg::back_state_type state_ff, state_in;

   logic [rpwd_pkg::STEP_W-1:0]    step_ff;
   logic [rpwd_pkg::CNT_SEQ_W-1:0] cnt_ff;
   logic [1:0]                     ch_ff;
   logic                           root_y_ff;
   logic [PW-1:0] mcand_ff, prod_ff;
   logic [RW-1:0] mplier_ff;
   logic [PW-1:0] a_ff, b_ff, pxx_ff, dx_ff, dy_ff, den_ff;
   logic [RW-1:0] rx_ff, ry_ff;
   logic [PW-1:0] rv_ff, rres_ff;
   logic [PW:0]   rem_ff;
   logic [FB:0]   q_ff;
   logic          neg_ff;
   logic signed [TW-1:0] total_ff;
   logic          tneg_ff;
   logic [rpwd_pkg::CORR_W-1:0] avgm_ff;
   logic          rsp_valid_ff;
   rpwd_pkg::rsp_data_type rsp_data_ff;

   logic [PW-1:0] op_a;
   logic [RW-1:0] op_b;
   logic [PW-1:0] prod_sum;
   logic          mul_last, root_last, div_last;
   logic [PW-1:0] rbit, rtrial;
   logic          rge;
   logic [PW:0]   rem2;
   logic          dge;
   logic [FB:0]   qclamp;
   logic [rpwd_pkg::MAG_W-1:0] tmag;
   logic [rpwd_pkg::MAG_W+rpwd_pkg::MAG_W-1:0] recip_prod;
   logic signed [rpwd_pkg::CORR_W:0] corr_wide;
   logic signed [rpwd_pkg::CORR_W:0] thr_wide;
   logic [rpwd_pkg::CORR_W-1:0] corr_pos;
   logic          rsp_load;

   // Operands of the current multiplication step.
   always_comb begin
      unique case (step_ff)
         rpwd_pkg::STEP_CROSS: begin
            op_a = PW'(head.cross_product_sum[ch_ff]);
            op_b = RW'(head.pixel_count);
         end
         rpwd_pkg::STEP_SXSY: begin
            op_a = PW'(head.image_sum[ch_ff]);
            op_b = RW'(head.pattern_sum[ch_ff]);
         end
         rpwd_pkg::STEP_XX_N: begin
            op_a = PW'(head.image_square_sum[ch_ff]);
            op_b = RW'(head.pixel_count);
         end
         rpwd_pkg::STEP_XX_S: begin
            op_a = PW'(head.image_sum[ch_ff]);
            op_b = RW'(head.image_sum[ch_ff]);
         end
         rpwd_pkg::STEP_YY_N: begin
            op_a = PW'(head.pattern_square_sum[ch_ff]);
            op_b = RW'(head.pixel_count);
         end
         rpwd_pkg::STEP_YY_S: begin
            op_a = PW'(head.pattern_sum[ch_ff]);
            op_b = RW'(head.pattern_sum[ch_ff]);
         end
         default: begin
            op_a = PW'(rx_ff);
            op_b = ry_ff;
         end
      endcase
   end

   assign prod_sum  = prod_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign mul_last  = cnt_ff == rpwd_pkg::CNT_SEQ_W'(RW - 1);
   assign root_last = cnt_ff == rpwd_pkg::CNT_SEQ_W'(RW - 1);
   assign div_last  = cnt_ff == rpwd_pkg::CNT_SEQ_W'(FB - 1);

   // One digit pair of the square root per cycle, from the top down.
   assign rbit   = PW'(1) << {rpwd_pkg::CNT_SEQ_W'(RW - 1) - cnt_ff, 1'b0};
   assign rtrial = rres_ff + rbit;
   assign rge    = rv_ff >= rtrial;

   // The remainder stays below the divisor, so its top bit is free to shift.
   assign rem2 = {rem_ff[PW-1:0], 1'b0};
   assign dge  = rem2 >= {1'b0, den_ff};

   assign qclamp = (q_ff > rpwd_pkg::COEF_ONE) ? rpwd_pkg::COEF_ONE : q_ff;

   assign tmag       = rpwd_pkg::MAG_W'(total_ff < 0 ? -total_ff : total_ff);
   assign recip_prod = tmag * rpwd_pkg::RECIP_3;

   assign corr_pos  = (avgm_ff > rpwd_pkg::CORR_W'(32767)) ? rpwd_pkg::CORR_W'(32767)
                                                           : avgm_ff;
   assign corr_wide = tneg_ff ? -$signed({1'b0, avgm_ff}) : $signed({1'b0, corr_pos});
   assign thr_wide  = $signed({1'b0, threshold});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpwd_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = rpwd_pkg::ST_LOAD;
            end
         end
         rpwd_pkg::ST_LOAD: state_in = rpwd_pkg::ST_MUL;
         rpwd_pkg::ST_MUL: begin
            if (mul_last) begin
               if (step_ff == rpwd_pkg::STEP_DEN) begin
                  state_in = rpwd_pkg::ST_MAG;
               end else if (step_ff == rpwd_pkg::STEP_YY_S) begin
                  state_in = rpwd_pkg::ST_RLOAD;
               end else begin
                  state_in = rpwd_pkg::ST_LOAD;
               end
            end
         end
         rpwd_pkg::ST_RLOAD: state_in = rpwd_pkg::ST_ROOT;
         rpwd_pkg::ST_ROOT: begin
            if (root_last) begin
               state_in = root_y_ff ? rpwd_pkg::ST_LOAD : rpwd_pkg::ST_RLOAD;
            end
         end
         rpwd_pkg::ST_MAG: state_in = rpwd_pkg::ST_DIV_CHK;
         rpwd_pkg::ST_DIV_CHK: begin
            if (den_ff == '0 || rem_ff >= {den_ff, 1'b0}) begin
               state_in = rpwd_pkg::ST_ACC;
            end else begin
               state_in = rpwd_pkg::ST_DIV;
            end
         end
         rpwd_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = rpwd_pkg::ST_ACC;
            end
         end
         rpwd_pkg::ST_ACC: begin
            state_in = (ch_ff == 2'(rpwd_pkg::NUM_CH - 1)) ? rpwd_pkg::ST_AVG
                                                           : rpwd_pkg::ST_LOAD;
         end
         rpwd_pkg::ST_AVG: state_in = rpwd_pkg::ST_DONE;
         rpwd_pkg::ST_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = rpwd_pkg::ST_IDLE;
            end
         end
         default: state_in = rpwd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_load = (state_ff == rpwd_pkg::ST_DONE) && !rsp_valid_ff;
      pop      = rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpwd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= rpwd_pkg::STEP_CROSS;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         root_y_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            rpwd_pkg::ST_IDLE: begin
               step_ff <= rpwd_pkg::STEP_CROSS;
               ch_ff   <= '0;
            end
            rpwd_pkg::ST_LOAD, rpwd_pkg::ST_RLOAD: cnt_ff <= '0;
            rpwd_pkg::ST_MUL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (mul_last && step_ff == rpwd_pkg::STEP_YY_S) begin
                  root_y_ff <= 1'b0;
               end else if (mul_last && step_ff != rpwd_pkg::STEP_DEN) begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            rpwd_pkg::ST_ROOT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (root_last) begin
                  root_y_ff <= 1'b1;
                  if (root_y_ff) begin
                     step_ff <= rpwd_pkg::STEP_DEN;
                  end
               end
            end
            rpwd_pkg::ST_DIV_CHK: cnt_ff <= '0;
            rpwd_pkg::ST_DIV: cnt_ff <= cnt_ff + 1'b1;
            rpwd_pkg::ST_ACC: begin
               step_ff <= rpwd_pkg::STEP_CROSS;
               if (ch_ff != 2'(rpwd_pkg::NUM_CH - 1)) begin
                  ch_ff <= ch_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         rpwd_pkg::ST_IDLE: total_ff <= '0;
         rpwd_pkg::ST_LOAD: begin
            mcand_ff  <= op_a;
            mplier_ff <= op_b;
            prod_ff   <= '0;
         end
         rpwd_pkg::ST_MUL: begin
            prod_ff   <= prod_sum;
            mcand_ff  <= {mcand_ff[PW-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[RW-1:1]};
            if (mul_last) begin
               unique case (step_ff)
                  rpwd_pkg::STEP_CROSS: a_ff <= prod_sum;
                  rpwd_pkg::STEP_SXSY:  b_ff <= prod_sum;
                  rpwd_pkg::STEP_XX_N, rpwd_pkg::STEP_YY_N: pxx_ff <= prod_sum;
                  rpwd_pkg::STEP_XX_S:
                     dx_ff <= (pxx_ff >= prod_sum) ? pxx_ff - prod_sum : '0;
                  rpwd_pkg::STEP_YY_S:
                     dy_ff <= (pxx_ff >= prod_sum) ? pxx_ff - prod_sum : '0;
                  default: den_ff <= prod_sum;
               endcase
            end
         end
         rpwd_pkg::ST_RLOAD: begin
            rv_ff   <= root_y_ff ? dy_ff : dx_ff;
            rres_ff <= '0;
         end
         rpwd_pkg::ST_ROOT: begin
            rv_ff   <= rge ? rv_ff - rtrial : rv_ff;
            rres_ff <= rge ? (rres_ff >> 1) + rbit : rres_ff >> 1;
            if (root_last) begin
               if (root_y_ff) begin
                  ry_ff <= RW'(rge ? (rres_ff >> 1) + rbit : rres_ff >> 1);
               end else begin
                  rx_ff <= RW'(rge ? (rres_ff >> 1) + rbit : rres_ff >> 1);
               end
            end
         end
         rpwd_pkg::ST_MAG: begin
            neg_ff <= a_ff < b_ff;
            rem_ff <= {1'b0, (a_ff < b_ff) ? b_ff - a_ff : a_ff - b_ff};
         end
         rpwd_pkg::ST_DIV_CHK: begin
            if (den_ff == '0) begin
               q_ff <= '0;
            end else if (rem_ff >= {den_ff, 1'b0}) begin
               q_ff <= rpwd_pkg::COEF_ONE;
            end else if (rem_ff >= {1'b0, den_ff}) begin
               q_ff   <= (FB + 1)'(1);
               rem_ff <= rem_ff - {1'b0, den_ff};
            end else begin
               q_ff <= '0;
            end
         end
         rpwd_pkg::ST_DIV: begin
            rem_ff <= dge ? rem2 - {1'b0, den_ff} : rem2;
            q_ff   <= {q_ff[FB-1:0], dge};
         end
         rpwd_pkg::ST_ACC: begin
            total_ff <= neg_ff ? total_ff - $signed(TW'(qclamp))
                               : total_ff + $signed(TW'(qclamp));
         end
         rpwd_pkg::ST_AVG: begin
            tneg_ff <= total_ff < 0;
            avgm_ff <= rpwd_pkg::CORR_W'(recip_prod >> rpwd_pkg::RECIP_SHIFT);
         end
         rpwd_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_data_ff.correlation_value <= rpwd_pkg::CORR_W'(corr_wide);
               if (corr_wide < -thr_wide) begin
                  rsp_data_ff.verdict <= rpwd_pkg::VERDICT_BELOW;
               end else if (corr_wide > thr_wide) begin
                  rsp_data_ff.verdict <= rpwd_pkg::VERDICT_ABOVE;
               end else begin
                  rsp_data_ff.verdict <= rpwd_pkg::VERDICT_NONE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      ch_ff <= 2'(rpwd_pkg::NUM_CH - 1))
      else $error("channel index out of range");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop))
      else $error("result appeared without a frame being retired");

   a_start_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpwd_pkg::ST_IDLE && state_in != rpwd_pkg::ST_IDLE) |-> !q_status.empty)
      else $error("back end started without a queued frame");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpwd_pkg::ST_DIV |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
